/* rtl/svt_pkg.sv */
`default_nettype none

package svt_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // broadcast to every cell
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] value;
    } cell_ctrl_t;

    // where a cell sits relative to the fill level
    typedef struct packed {
        logic valid;
        logic slot;
    } cell_pos_t;

endpackage

`default_nettype wire

/* rtl/svt_req_if.sv */
`default_nettype none

interface svt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [31:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

/* rtl/svt_rsp_if.sv */
`default_nettype none

interface svt_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] item;
    logic               last;

    modport source (output valid, output status, output item, output last, input ready);
    modport sink (input valid, input status, input item, input last, output ready);
endinterface

`default_nettype wire

/* rtl/svt_cell.sv */
`default_nettype none

module svt_cell (
    input  wire                              clk,
    input  wire svt_pkg::cell_ctrl_t         ctrl,
    input  wire svt_pkg::cell_pos_t          pos,
    input  wire                              left_take,
    input  wire signed [svt_pkg::VALUE_W-1:0] left_value,
    input  wire signed [svt_pkg::VALUE_W-1:0] right_value,
    output logic                             take,
    output logic                             eq,
    output logic signed [svt_pkg::VALUE_W-1:0] stored
);
    import svt_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      less;

    always_comb
    begin
        less = ctrl.value < value_reg;
        take = (pos.valid && less) || pos.slot;
        eq   = pos.valid && (value_reg == ctrl.value);
        value_next = value_reg;
        if (ctrl.ins && take)
        begin
            value_next = left_take ? left_value : ctrl.value;
        end
        else if (ctrl.rem && pos.valid && !(value_reg < ctrl.value))
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign stored = value_reg;

endmodule

`default_nettype wire

/* rtl/sorted_value_table.sv */
// insert, remove and search: one item accepted per cycle when the output is free and no list is running,
// result presented in the cycle after acceptance
// list: one stored value per cycle read out of the cell row while the output is free
// an update shifts the cells from the insert or remove position onward in the cycle of acceptance
// reset (rst_n low, asynchronous) empties the table; cell contents are not cleared
`default_nettype none

module sorted_value_table #(
    parameter int CAPACITY = svt_pkg::CAPACITY_DEFAULT
) (
    input wire       clk,
    input wire       rst_n,
    svt_req_if.sink  req,
    svt_rsp_if.source rsp
);
    import svt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      listing_reg, listing_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      out_valid_reg, out_valid_next;
    status_t                   status_reg, status_next;
    logic signed [VALUE_W-1:0] item_reg, item_next;
    logic                      last_reg, last_next;

    cell_ctrl_t                ctrl;
    logic [CAPACITY-1:0]       take_vec;
    logic [CAPACITY-1:0]       eq_vec;
    logic signed [VALUE_W-1:0] cell_value [CAPACITY];

    logic    out_free;
    logic    accept;
    logic    found;
    logic    full;
    opcode_t op;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !listing_reg && out_free;
    assign accept    = req.valid && req.ready;
    assign op        = opcode_t'(req.opcode);
    assign found     = |eq_vec;
    assign full      = count_reg == CNT_W'(CAPACITY);

    assign ctrl.ins   = accept && (op == OP_INSERT) && !full;
    assign ctrl.rem   = accept && (op == OP_REMOVE) && found;
    assign ctrl.value = req.value;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            localparam logic [CNT_W-1:0] POS = CNT_W'(i);
            cell_pos_t                 pos;
            logic                      left_take;
            logic signed [VALUE_W-1:0] left_value;
            logic signed [VALUE_W-1:0] right_value;

            assign pos.valid = POS < count_reg;
            assign pos.slot  = POS == count_reg;

            if (i == 0)
            begin : g_head
                assign left_take  = 1'b0;
                assign left_value = req.value;
            end
            else
            begin : g_body
                assign left_take  = take_vec[i-1];
                assign left_value = cell_value[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_value = cell_value[i];
            end
            else
            begin : g_inner
                assign right_value = cell_value[i+1];
            end

            svt_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .pos         (pos),
                .left_take   (left_take),
                .left_value  (left_value),
                .right_value (right_value),
                .take        (take_vec[i]),
                .eq          (eq_vec[i]),
                .stored      (cell_value[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        listing_next   = listing_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        item_next      = item_reg;
        last_next      = last_reg;

        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_DONE;
            item_next      = '0;
            last_next      = 1'b1;
            case (op)
                OP_INSERT:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                OP_REMOVE:
                begin
                    if (found)
                        count_next = count_reg - CNT_W'(1);
                    else
                        status_next = ST_NOT_FOUND;
                end
                OP_SEARCH:
                begin
                    if (!found)
                        status_next = ST_NOT_FOUND;
                end
                OP_LIST:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        listing_next   = 1'b1;
                        idx_next       = '0;
                    end
                end
                default:
                begin
                    status_next = ST_NOT_FOUND;
                end
            endcase
        end
        else if (listing_reg && out_free)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_DONE;
            item_next      = cell_value[idx_reg];
            last_next      = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
            idx_next       = idx_reg + IDX_W'(1);
            if (last_next)
                listing_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            listing_reg   <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            listing_reg   <= listing_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        item_reg   <= item_next;
        last_reg   <= last_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.item   = item_reg;
    assign rsp.last   = last_reg;

endmodule

`default_nettype wire
